FILE: hw/rtl/sbpa_pkg.sv
package sbpa_pkg;

    localparam int Bands = 32;
    localparam int Bins = 512;
    localparam int MagWidth = 24;
    localparam int BinAw = 9;
    localparam int EdgeAw = 6;
    localparam int BandAw = 5;
    localparam int LowEnd = Bands / 3;
    localparam int MidEnd = 2 * Bands / 3;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_EDGE = 2'd1,
        OP_FRAME = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    localparam logic [2:0] REG_NOISE = 3'd0;
    localparam logic [2:0] REG_SENS = 3'd1;
    localparam logic [2:0] REG_LOW = 3'd2;
    localparam logic [2:0] REG_MID = 3'd3;
    localparam logic [2:0] REG_HIGH = 3'd4;
    localparam logic [2:0] REG_DECAY = 3'd5;
    localparam logic [2:0] REG_ALPHA = 3'd6;
    localparam logic [2:0] REG_CEIL = 3'd7;

    // Datapath micro-operations issued by the controller.
    typedef enum logic [3:0] {
        DP_IDLE,
        DP_SQ,
        DP_SQRT,
        DP_EDGE,
        DP_BAND,
        DP_SCALE,
        DP_PEAK,
        DP_SMOOTH,
        DP_DIV,
        DP_EMIT
    } t_dp_cmd;

    typedef struct packed {
        t_dp_cmd cmd;
        logic first;
    } t_cmd;

    // The last flag marks that the phase just finished worked on the final band.
    typedef struct packed {
        logic done;
        logic out_busy;
        logic last;
    } t_status;

endpackage

FILE: hw/rtl/sbpa_ctrl.sv
module sbpa_ctrl
    import sbpa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT, S_EDGE, S_BAND, S_SCALE, S_PEAK,
        S_SMOOTH, S_DIV, S_EMIT
    } t_state;

    t_state r_state;
    logic   r_first;

    // Each phase runs until the datapath reports done. The first band loop
    // forms all peaks; the second smooths and emits once the maximum is known.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b0;
        end else begin
            r_first <= 1'b0;
            case (r_state)
                S_IDLE:   if (i_start) begin r_state <= S_SQ; r_first <= 1'b1; end
                S_SQ:     if (i_status.done) begin r_state <= S_SQRT; r_first <= 1'b1; end
                S_SQRT:   if (i_status.done) begin r_state <= S_EDGE; r_first <= 1'b1; end
                S_EDGE:   if (i_status.done) begin r_state <= S_BAND; r_first <= 1'b1; end
                S_BAND:   if (i_status.done) begin r_state <= S_SCALE; r_first <= 1'b1; end
                S_SCALE:  if (i_status.done) begin r_state <= S_PEAK; r_first <= 1'b1; end
                S_PEAK: begin
                    if (i_status.done) begin
                        r_state <= i_status.last ? S_SMOOTH : S_EDGE;
                        r_first <= 1'b1;
                    end
                end
                S_SMOOTH: if (i_status.done) begin r_state <= S_DIV; r_first <= 1'b1; end
                S_DIV:    if (i_status.done) begin r_state <= S_EMIT; r_first <= 1'b1; end
                S_EMIT: begin
                    if (i_status.done) begin
                        if (i_status.last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_SMOOTH;
                            r_first <= 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.first = r_first;
        case (r_state)
            S_SQ:     o_cmd.cmd = DP_SQ;
            S_SQRT:   o_cmd.cmd = DP_SQRT;
            S_EDGE:   o_cmd.cmd = DP_EDGE;
            S_BAND:   o_cmd.cmd = DP_BAND;
            S_SCALE:  o_cmd.cmd = DP_SCALE;
            S_PEAK:   o_cmd.cmd = DP_PEAK;
            S_SMOOTH: o_cmd.cmd = DP_SMOOTH;
            S_DIV:    o_cmd.cmd = DP_DIV;
            S_EMIT:   o_cmd.cmd = DP_EMIT;
            default:  o_cmd.cmd = DP_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE) || i_status.out_busy;

endmodule

FILE: hw/rtl/sbpa_dp.sv
module sbpa_dp
    import sbpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    // item writes
    input  logic        i_load_we,
    input  logic        i_edge_we,
    input  logic [8:0]  i_slot,
    input  logic [23:0] i_magnitude,
    input  logic [9:0]  i_edge_bin,
    input  logic        i_frame_start,
    input  logic [7:0]  i_column_height,
    // registers
    input  logic [16:0] i_noise_ratio,
    input  logic [15:0] i_sens,
    input  logic [15:0] i_low_gain,
    input  logic [15:0] i_mid_gain,
    input  logic [15:0] i_high_gain,
    input  logic [16:0] i_decay,
    input  logic [16:0] i_alpha,
    input  logic [9:0]  i_ceiling,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_band_index,
    output logic [7:0]  o_height,
    output logic        o_last
);

    localparam int SqW = 2 * MagWidth;

    // Stores.
    logic [MagWidth-1:0] r_bins [Bins];
    logic [9:0]          r_edges [Bands+1];
    logic [31:0]         r_peak [Bands];
    logic [31:0]         r_smooth [Bands];
    logic [Bands-1:0]    r_peak_ok;
    logic [Bands-1:0]    r_smooth_ok;

    logic [BinAw-1:0]    r_bin_ra;
    logic [MagWidth-1:0] r_bin_rd;
    logic [EdgeAw-1:0]   r_edge_ra;
    logic [9:0]          r_edge_rd;

    // Working registers.
    logic [7:0]          r_colh;
    logic [BinAw:0]      r_cnt;
    logic [2:0]          r_pipe;
    logic [63:0]         r_sum_sq;
    logic [63:0]         r_rad;
    logic [31:0]         r_root;
    logic [5:0]          r_sqi;
    logic [48:0]         r_thr;
    logic [BandAw-1:0]   r_band;
    logic [9:0]          r_from;
    logic [BinAw:0]      r_to;
    logic [MagWidth+BinAw:0] r_bsum;
    logic [49:0]         r_prod;
    logic [44:0]         r_v;
    logic [31:0]         r_g;
    logic [31:0]         r_maxv;
    logic [31:0]         r_fmax;
    logic [31:0]         r_sm;
    logic [39:0]         r_num;
    logic [39:0]         r_rem;
    logic [8:0]          r_quo;
    logic [5:0]          r_dstep;
    logic                r_done;
    logic                r_lastb;
    logic                r_valid;
    logic [5:0]          r_oband;
    logic [7:0]          r_oh;
    logic                r_olast;
    logic [1:0]          r_ph;

    logic [15:0] w_gain;
    logic [16:0] w_alpha;
    logic [31:0] w_peak_rd;
    logic [31:0] w_smooth_rd;
    logic [SqW-1:0] w_sq;
    logic [64:0] w_acc;

    assign w_peak_rd   = r_peak_ok[r_band] ? r_peak[r_band] : 32'd0;
    assign w_smooth_rd = r_smooth_ok[r_band] ? r_smooth[r_band] : 32'd0;
    assign w_alpha     = i_alpha[16] ? 17'h10000 : i_alpha;
    assign w_sq        = r_bin_rd * r_bin_rd;
    assign w_acc       = {1'b0, r_sum_sq} + {{(65-SqW){1'b0}}, w_sq};

    always_comb begin
        if ({1'b0, r_band} < 6'(LowEnd)) begin
            w_gain = i_low_gain;
        end else if ({1'b0, r_band} < 6'(MidEnd)) begin
            w_gain = i_mid_gain;
        end else begin
            w_gain = i_high_gain;
        end
    end

    // Bin memory and edge table: one write port, one registered read.
    always_ff @(posedge i_clk) begin
        if (i_load_we) begin
            r_bins[i_slot[BinAw-1:0]] <= i_magnitude[MagWidth-1:0];
        end
        r_bin_rd <= r_bins[r_bin_ra];
        if (i_edge_we) begin
            r_edges[i_slot[EdgeAw-1:0]] <= i_edge_bin;
        end
        r_edge_rd <= r_edges[r_edge_ra];
    end

    // Frame-end datapath.
    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (i_frame_start) begin
            r_colh <= i_column_height;
        end
        case (i_cmd.cmd)
            // Sum of squares, one bin per cycle, through the registered read port.
            DP_SQ: begin
                if (i_cmd.first) begin
                    r_cnt    <= '0;
                    r_pipe   <= '0;
                    r_sum_sq <= '0;
                    r_bin_ra <= '0;
                    r_band   <= '0;
                    r_maxv   <= '0;
                end else begin
                    if (r_cnt < (BinAw+1)'(Bins)) begin
                        r_cnt    <= r_cnt + 1'b1;
                        r_bin_ra <= r_cnt[BinAw-1:0] + 1'b1;
                    end
                    r_pipe <= {r_pipe[1:0], r_cnt < (BinAw+1)'(Bins)};
                    if (r_pipe[0]) begin
                        r_sum_sq <= w_acc[64] ? {64{1'b1}} : w_acc[63:0];
                    end
                    if (r_cnt == (BinAw+1)'(Bins) && r_pipe[0] && !r_done) begin
                        r_done <= 1'b1;
                    end
                end
            end
            // Integer square root, one result bit per cycle. The radicand
            // stays below 2^48, so the root fits in 24 bits.
            DP_SQRT: begin
                if (i_cmd.first) begin
                    r_rad  <= r_sum_sq >> BinAw;
                    r_root <= '0;
                    r_sqi  <= 6'd23;
                end else if (!r_done) begin
                    logic [23:0] trial;
                    logic [47:0] t;
                    trial = r_root[23:0] | (24'd1 << r_sqi);
                    t = trial * trial;
                    if ({16'd0, t} <= r_rad) begin
                        r_root <= {8'd0, trial};
                    end
                    if (r_sqi == 6'd0) begin
                        r_done <= 1'b1;
                    end else begin
                        r_sqi <= r_sqi - 1'b1;
                    end
                end
            end
            // Fetch edges of the current band.
            DP_EDGE: begin
                if (i_cmd.first) begin
                    r_thr   <= r_root * i_noise_ratio;
                    r_edge_ra <= {1'b0, r_band};
                    r_pipe  <= '0;
                end else begin
                    r_pipe <= r_pipe + 1'b1;
                    case (r_pipe)
                        3'd1: begin
                            r_from <= (r_edge_rd > 10'(Bins-1)) ? 10'(Bins-1) : r_edge_rd;
                            r_edge_ra <= r_edge_ra + 1'b1;
                        end
                        3'd3: begin
                            if (r_edge_rd < r_from + 1'b1) begin
                                r_to <= (BinAw+1)'(r_from + 1'b1);
                            end else if (r_edge_rd > 10'(Bins)) begin
                                r_to <= (BinAw+1)'(Bins);
                            end else begin
                                r_to <= r_edge_rd[BinAw:0];
                            end
                            r_done <= 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            // Threshold-gated sum over the band's bins.
            DP_BAND: begin
                if (i_cmd.first) begin
                    r_cnt    <= r_from[BinAw:0];
                    r_bin_ra <= r_from[BinAw-1:0];
                    r_bsum   <= '0;
                    r_pipe   <= '0;
                end else begin
                    if (r_cnt < r_to) begin
                        r_cnt    <= r_cnt + 1'b1;
                        r_bin_ra <= r_cnt[BinAw-1:0] + 1'b1;
                    end
                    r_pipe <= {r_pipe[1:0], r_cnt < r_to};
                    if (r_pipe[0] && ({9'd0, r_bin_rd, 16'd0} > r_thr)) begin
                        r_bsum <= r_bsum + (MagWidth+BinAw+1)'(r_bin_rd);
                    end
                    if (r_cnt == r_to && r_pipe[0] && !r_done) begin
                        r_done <= 1'b1;
                    end
                end
            end
            // Sensitivity multiply and clamp, then gain multiply and clamp.
            DP_SCALE: begin
                if (i_cmd.first) begin
                    r_pipe <= '0;
                end else begin
                    r_pipe <= r_pipe + 1'b1;
                    case (r_pipe)
                        3'd0: r_prod <= 50'(r_bsum) * 50'(i_sens);
                        3'd1: r_v <= (r_prod[49:4] > 46'h1000_0000_0000)
                                     ? 45'h1000_0000_0000 : r_prod[48:4];
                        3'd2: r_prod <= 50'((61'(r_v) * 61'(w_gain)) >> 12);
                        3'd3: begin
                            r_g <= (r_prod > 50'hFFFF_FFFF) ? 32'hFFFF_FFFF : r_prod[31:0];
                            r_done <= 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            // Decay with peak hold, running maximum, then step to the next band.
            DP_PEAK: begin
                if (i_cmd.first) begin
                    r_pipe <= '0;
                end else begin
                    r_pipe <= r_pipe + 1'b1;
                    case (r_pipe)
                        3'd0: r_prod <= 50'((49'(w_peak_rd) * 49'(i_decay)) >> 16);
                        3'd1: begin
                            logic [31:0] p;
                            p = (r_prod > 50'hFFFF_FFFF) ? 32'hFFFF_FFFF : r_prod[31:0];
                            if (r_g > p) p = r_g;
                            r_peak[r_band]    <= p;
                            r_peak_ok[r_band] <= 1'b1;
                            if (p > r_maxv) r_maxv <= p;
                            r_lastb <= (r_band == BandAw'(Bands-1));
                            r_band  <= (r_band == BandAw'(Bands-1)) ? '0 : r_band + 1'b1;
                            r_done <= 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            // After the last band: clamp the maximum, then EMA per band.
            DP_SMOOTH: begin
                if (i_cmd.first) begin
                    r_pipe <= '0;
                end else begin
                    r_pipe <= r_pipe + 1'b1;
                    case (r_pipe)
                        3'd0: begin
                            if (r_maxv > {14'd0, i_ceiling, 8'd0}) begin
                                r_fmax <= {14'd0, i_ceiling, 8'd0};
                            end else begin
                                r_fmax <= r_maxv;
                            end
                            r_prod <= 50'(49'(w_smooth_rd) * 49'(17'h10000 - w_alpha));
                        end
                        3'd1: r_num <= 40'((51'(r_prod) +
                                   51'(49'(w_peak_rd) * 49'(w_alpha))) >> 16);
                        3'd2: begin
                            r_sm <= r_num[31:0];
                            r_smooth[r_band]    <= r_num[31:0];
                            r_smooth_ok[r_band] <= 1'b1;
                            r_done <= 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            // Restoring division of smooth*colh by frame_max.
            DP_DIV: begin
                if (i_cmd.first) begin
                    r_num   <= 40'(r_sm) * 40'(r_colh);
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_dstep <= 6'd40;
                end else if (!r_done) begin
                    logic [40:0] rr;
                    rr = {r_rem, r_num[39]};
                    r_num <= r_num << 1;
                    if (rr >= {9'd0, r_fmax}) begin
                        r_rem <= 40'(rr - {9'd0, r_fmax});
                        r_quo <= (r_quo[8] || r_dstep > 6'd9) ? 9'h100 : {r_quo[7:0], 1'b1};
                    end else begin
                        r_rem <= rr[39:0];
                        r_quo <= r_quo[8] ? 9'h100 : {r_quo[7:0], 1'b0};
                    end
                    r_dstep <= r_dstep - 1'b1;
                    if (r_dstep == 6'd1) begin
                        r_done <= 1'b1;
                    end
                end
            end
            // Load the output register, then step to the next band.
            DP_EMIT: begin
                if (i_cmd.first) begin
                    r_ph <= '0;
                end else if (r_ph == 2'd0 && !r_valid) begin
                    r_ph <= 2'd1;
                end else if (r_ph == 2'd1) begin
                    r_ph    <= 2'd2;
                    r_done  <= 1'b1;
                    r_lastb <= (r_band == BandAw'(Bands-1));
                    r_band  <= (r_band == BandAw'(Bands-1)) ? '0 : r_band + 1'b1;
                end
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            r_peak_ok   <= '0;
            r_smooth_ok <= '0;
        end
    end

    // Output register loaded in the emit phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            if (i_cmd.cmd == DP_EMIT && !i_cmd.first && r_ph == 2'd0 && !r_valid) begin
                r_valid  <= 1'b1;
                r_oband  <= {1'b0, r_band};
                r_olast  <= (r_band == BandAw'(Bands-1));
                if (r_fmax == 32'd0) begin
                    r_oh <= 8'd0;
                end else if (r_quo > {1'b0, r_colh}) begin
                    r_oh <= r_colh;
                end else begin
                    r_oh <= r_quo[7:0];
                end
            end
        end
    end

    assign o_status.done     = r_done;
    assign o_status.out_busy = r_valid;
    assign o_status.last     = r_lastb;
    assign o_valid      = r_valid;
    assign o_band_index = r_oband;
    assign o_height     = r_oh;
    assign o_last       = r_olast;

endmodule

FILE: hw/rtl/sbpa_seq.sv
module sbpa_seq
    import sbpa_pkg::*;
(
    input  t_cmd i_cmd,
    output t_cmd o_cmd
);

    // Command path from the controller to the datapath; the band loops are
    // sequenced by the controller from the datapath's last-band status.
    assign o_cmd = i_cmd;

endmodule

FILE: hw/rtl/spectrum_band_peak_analyzer.sv
// Spectrum band peak analyzer.
// Input channel: i_valid/o_stall with operation, slot, magnitude, edge_bin
// and column_height. Operation 0 stores a bin, 1 stores a band edge, both
// back to back. Operation 2 starts the frame-end pass; operation 3 is
// dropped.
// Output channel: o_valid/i_stall with band_index, height, last; one item
// per band, band 0 first, last set on the final band.
// Frame end walks the bin memory once for the sum of squares and runs a
// 24-step square root. A first band loop fetches edges, sums the band's
// bins through the single read port and scales and applies peak hold. A
// second band loop smooths, divides in 40 steps and loads the output
// register.
// o_stall is high during the frame-end pass until the last item is taken.
// A receiver stall holds the output register and pauses the band loop.
// Reset clears control state, band peaks and smoothed values and loads the
// configuration defaults; bins and edges stay undefined until written.
module spectrum_band_peak_analyzer
    import sbpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [8:0]  i_slot,
    input  logic [23:0] i_magnitude,
    input  logic [9:0]  i_edge_bin,
    input  logic [7:0]  i_column_height,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_band_index,
    output logic [7:0]  o_height,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    logic [16:0] r_noise, r_decay, r_alpha;
    logic [15:0] r_sens, r_low, r_mid, r_high;
    logic [9:0]  r_ceil;
    logic        w_busy, w_acc, w_start;
    t_cmd        w_cmd, w_cmd2;
    t_status     w_status;

    assign o_stall     = w_busy;
    assign o_cfg_ready = 1'b1;
    assign w_acc   = i_valid && !o_stall;
    assign w_start = w_acc && (t_op'(i_operation) == OP_FRAME);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise <= 17'd6554;
            r_sens  <= 16'd4096;
            r_low   <= 16'd4096;
            r_mid   <= 16'd4096;
            r_high  <= 16'd4096;
            r_decay <= 17'd62259;
            r_alpha <= 17'd19661;
            r_ceil  <= 10'd200;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_NOISE: r_noise <= i_cfg_data;
                REG_SENS:  r_sens  <= i_cfg_data[15:0];
                REG_LOW:   r_low   <= i_cfg_data[15:0];
                REG_MID:   r_mid   <= i_cfg_data[15:0];
                REG_HIGH:  r_high  <= i_cfg_data[15:0];
                REG_DECAY: r_decay <= i_cfg_data;
                REG_ALPHA: r_alpha <= i_cfg_data;
                REG_CEIL:  r_ceil  <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    sbpa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_status(w_status), .o_cmd(w_cmd), .o_busy(w_busy)
    );

    sbpa_seq u_seq (
        .i_cmd(w_cmd), .o_cmd(w_cmd2)
    );

    sbpa_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd2), .o_status(w_status),
        .i_load_we(w_acc && t_op'(i_operation) == OP_LOAD),
        .i_edge_we(w_acc && t_op'(i_operation) == OP_EDGE && i_slot <= 9'(Bands)),
        .i_slot(i_slot), .i_magnitude(i_magnitude), .i_edge_bin(i_edge_bin),
        .i_frame_start(w_start), .i_column_height(i_column_height),
        .i_noise_ratio(r_noise), .i_sens(r_sens), .i_low_gain(r_low),
        .i_mid_gain(r_mid), .i_high_gain(r_high), .i_decay(r_decay),
        .i_alpha(r_alpha), .i_ceiling(r_ceil),
        .o_valid(o_valid), .i_stall(i_stall), .o_band_index(o_band_index),
        .o_height(o_height), .o_last(o_last)
    );

endmodule

FILE: hw/rtl/sbpa_checker.sv
module sbpa_checker
    import sbpa_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_stall,
    input logic [5:0] o_band_index,
    input logic       o_last
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_band_index))
        else $error("stalled result changed");

    // Last marks the final band only.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_band_index == 6'(Bands-1))))
        else $error("last flag wrong");

    // Results appear only while the input side is held off.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result while idle");

endmodule

bind spectrum_band_peak_analyzer sbpa_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_stall(o_stall), .o_band_index(o_band_index), .o_last(o_last)
);

FILE: verif/spectrum_band_peak_analyzer_tb.sv
`timescale 1ns / 1ps

module spectrum_band_peak_analyzer_tb;
    import sbpa_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct {
        logic [5:0] band_index;
        logic [7:0] height;
        logic       last;
    } t_band_out;

    // One row of the directed table; a fixed height of -1 means the expected
    // heights come from the frame model.
    typedef struct {
        t_op         op;
        logic [8:0]  slot;
        logic [23:0] mag;
        logic [9:0]  edge_bin;
        logic [7:0]  colh;
        int          fixed_h;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_operation;
    logic [8:0]  i_slot;
    logic [23:0] i_magnitude;
    logic [9:0]  i_edge_bin;
    logic [7:0]  i_column_height;
    logic        o_valid;
    logic        i_stall;
    logic [5:0]  o_band_index;
    logic [7:0]  o_height;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [16:0] i_cfg_data;

    // Model state and configuration.
    logic [23:0] bin_mem [Bins];
    logic [9:0]  edge_mem [Bands + 1];
    logic [31:0] peak_mem [Bands];
    logic [31:0] smooth_mem [Bands];
    logic [16:0] cfg_noise, cfg_decay, cfg_alpha;
    logic [15:0] cfg_sens, cfg_low, cfg_mid, cfg_high;
    logic [9:0]  cfg_ceil;

    t_band_out pending_bands[$];
    int  error_count;
    int  cycle_count;
    bit  calm;

    spectrum_band_peak_analyzer dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver stalls at random except during calm stretches.
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 34);
        end
    end

    // Compare every accepted band item with the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_bands.size() == 0) begin
                $error("unexpected band item: band_index %0d height %0d", o_band_index,
                       o_height);
                error_count++;
            end else begin
                t_band_out e;
                e = pending_bands.pop_front();
                if (o_band_index !== e.band_index) begin
                    $error("band_index: expected %0d, actual %0d", e.band_index, o_band_index);
                    error_count++;
                end
                if (o_height !== e.height) begin
                    $error("height: expected %0d, actual %0d", e.height, o_height);
                    error_count++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %0d, actual %0d", e.last, o_last);
                    error_count++;
                end
            end
        end
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned one;
        res = 0;
        one = 64'd1 << 62;
        while (one > x) one >>= 2;
        while (one != 0) begin
            if (x >= res + one) begin
                x -= res + one;
                res = (res >> 1) + one;
            end else begin
                res >>= 1;
            end
            one >>= 2;
        end
        return res;
    endfunction

    // Frame-end computation: threshold, band sums, peaks, smoothing, heights.
    task automatic predict_frame(input logic [7:0] colh, input int fixed_h);
        longint unsigned sq_sum, sq, rms, thr, maxv, a, lo, hi, s, v, g, gain, p, sm, h;
        t_band_out e;
        sq_sum = 0;
        maxv = 0;
        for (int i = 0; i < Bins; i++) begin
            sq = longint'(bin_mem[i]) * longint'(bin_mem[i]);
            sq_sum = (sq_sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                              : sq_sum + sq;
        end
        rms = int_sqrt(sq_sum / Bins);
        thr = rms * cfg_noise;
        for (int b = 0; b < Bands; b++) begin
            lo = edge_mem[b];
            hi = edge_mem[b + 1];
            if (lo > Bins - 1) lo = Bins - 1;
            if (hi < lo + 1) hi = lo + 1;
            if (hi > Bins) hi = Bins;
            s = 0;
            for (longint unsigned i = lo; i < hi; i++) begin
                if ((longint'(bin_mem[i]) << 16) > thr) s += bin_mem[i];
            end
            v = (s * cfg_sens) >> 4;
            if (v > (64'd1 << 44)) v = 64'd1 << 44;
            gain = (b < LowEnd) ? cfg_low : (b < MidEnd) ? cfg_mid : cfg_high;
            g = (v * gain) >> 12;
            if (g > 64'hFFFF_FFFF) g = 64'hFFFF_FFFF;
            p = (longint'(peak_mem[b]) * cfg_decay) >> 16;
            if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
            if (g > p) p = g;
            peak_mem[b] = p[31:0];
            if (p > maxv) maxv = p;
        end
        if (maxv > (longint'(cfg_ceil) << 8)) maxv = longint'(cfg_ceil) << 8;
        a = (cfg_alpha > 17'd65536) ? 65536 : cfg_alpha;
        for (int b = 0; b < Bands; b++) begin
            sm = ((65536 - a) * smooth_mem[b] + a * peak_mem[b]) >> 16;
            smooth_mem[b] = sm[31:0];
            h = 0;
            if (maxv != 0) begin
                h = (sm * colh) / maxv;
                if (h > colh) h = colh;
            end
            e.band_index = b;
            e.height = (fixed_h >= 0) ? fixed_h : h[7:0];
            e.last = (b == Bands - 1);
            pending_bands.push_back(e);
        end
    endtask

    task automatic apply_item(input t_op op, input logic [8:0] slot, input logic [23:0] mag,
                              input logic [9:0] edge_bin, input logic [7:0] colh,
                              input int fixed_h);
        case (op)
            OP_LOAD: bin_mem[slot] = mag;
            OP_EDGE: if (slot <= Bands) edge_mem[slot] = edge_bin;
            OP_FRAME: predict_frame(colh, fixed_h);
            default: ;
        endcase
    endtask

    // Present one item, with an optional random gap first, and wait for it.
    task automatic send_item(input t_op op, input logic [8:0] slot, input logic [23:0] mag,
                             input logic [9:0] edge_bin, input logic [7:0] colh,
                             input int fixed_h = -1);
        if (!calm && $urandom_range(99) < 34) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_slot <= slot;
        i_magnitude <= mag;
        i_edge_bin <= edge_bin;
        i_column_height <= colh;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        apply_item(op, slot, mag, edge_bin, colh, fixed_h);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        case (idx)
            REG_NOISE: cfg_noise = data;
            REG_SENS: cfg_sens = data[15:0];
            REG_LOW: cfg_low = data[15:0];
            REG_MID: cfg_mid = data[15:0];
            REG_HIGH: cfg_high = data[15:0];
            REG_DECAY: cfg_decay = data;
            REG_ALPHA: cfg_alpha = data;
            default: cfg_ceil = data[9:0];
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop sending until every expected band item has come, then let the
    // block settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_bands.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_all(input logic [16:0] noise, input logic [16:0] sens,
                             input logic [16:0] lo, input logic [16:0] mid,
                             input logic [16:0] hi, input logic [16:0] dec,
                             input logic [16:0] alp, input logic [16:0] ceil_v);
        drain();
        write_reg(REG_NOISE, noise);
        write_reg(REG_SENS, sens);
        write_reg(REG_LOW, lo);
        write_reg(REG_MID, mid);
        write_reg(REG_HIGH, hi);
        write_reg(REG_DECAY, dec);
        write_reg(REG_ALPHA, alp);
        write_reg(REG_CEIL, ceil_v);
    endtask

    function automatic logic [23:0] rand_mag();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(0, 255);
            2: return $urandom_range(0, 65535);
            default: return 24'hFFFFFF - $urandom_range(0, 15);
        endcase
    endfunction

    // Random mix of bin loads, edge writes, dropped items and frame ends.
    task automatic random_items(input int count);
        int r;
        int s;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 55) begin
                send_item(OP_LOAD, $urandom, rand_mag(), $urandom, $urandom);
            end else if (r < 80) begin
                s = $urandom_range(0, Bands);
                if ($urandom_range(9) == 0) begin
                    send_item(OP_EDGE, $urandom, $urandom, $urandom, $urandom);
                end else if ($urandom_range(4) == 0) begin
                    send_item(OP_EDGE, s, $urandom, $urandom_range(0, 1023), $urandom);
                end else begin
                    send_item(OP_EDGE, s, $urandom,
                              s * 16 + $urandom_range(0, 12) - 6 + (s == 0 ? 6 : 0),
                              $urandom);
                end
            end else if (r < 86) begin
                send_item(OP_NONE, $urandom, $urandom, $urandom, $urandom);
            end else begin
                send_item(OP_FRAME, $urandom, $urandom, $urandom, $urandom);
            end
        end
        send_item(OP_FRAME, $urandom, $urandom, $urandom, $urandom_range(1, 255));
    endtask

    t_row directed [] = '{
        '{OP_FRAME, 9'd0, 24'd0, 10'd0, 8'd255, 0},
        '{OP_NONE, 9'h1FF, 24'hFFFFFF, 10'h3FF, 8'hFF, -1},
        '{OP_LOAD, 9'd5, 24'hFFFFFF, 10'd0, 8'd0, -1},
        '{OP_LOAD, 9'd511, 24'h800000, 10'h3FF, 8'd0, -1},
        '{OP_LOAD, 9'd0, 24'h000001, 10'd0, 8'd0, -1},
        '{OP_LOAD, 9'd100, 24'h555555, 10'd0, 8'd0, -1},
        '{OP_LOAD, 9'd200, 24'hAAAAAA, 10'd0, 8'd0, -1},
        '{OP_EDGE, 9'd33, 24'd0, 10'd7, 8'd0, -1},
        '{OP_EDGE, 9'h1FF, 24'd0, 10'd9, 8'd0, -1},
        '{OP_EDGE, 9'd0, 24'd0, 10'd0, 8'd0, -1},
        '{OP_EDGE, 9'd32, 24'd0, 10'd512, 8'd0, -1},
        '{OP_FRAME, 9'd0, 24'd0, 10'd0, 8'd255, -1},
        '{OP_FRAME, 9'd0, 24'd0, 10'd0, 8'd0, 0},
        '{OP_EDGE, 9'd31, 24'd0, 10'h3FF, 8'd0, -1},
        '{OP_EDGE, 9'd3, 24'd0, 10'd2, 8'd0, -1},
        '{OP_FRAME, 9'd0, 24'd0, 10'd0, 8'd128, -1},
        '{OP_FRAME, 9'd0, 24'd0, 10'd0, 8'd1, -1}
    };

    initial begin
        error_count = 0;
        cycle_count = 0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = OP_NONE;
        i_slot = '0;
        i_magnitude = '0;
        i_edge_bin = '0;
        i_column_height = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_NOISE;
        i_cfg_data = '0;
        cfg_noise = 17'd6554;
        cfg_sens = 16'd4096;
        cfg_low = 16'd4096;
        cfg_mid = 16'd4096;
        cfg_high = 16'd4096;
        cfg_decay = 17'd62259;
        cfg_alpha = 17'd19661;
        cfg_ceil = 10'd200;
        for (int b = 0; b < Bands; b++) begin
            peak_mem[b] = '0;
            smooth_mem[b] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every bin and edge is written before the first frame end.
        calm = 1'b1;
        for (int i = 0; i < Bins; i++) send_item(OP_LOAD, i, 24'd0, 10'd0, 8'd0);
        for (int i = 0; i <= Bands; i++) send_item(OP_EDGE, i, 24'd0, i * 16, 8'd0);
        calm = 1'b0;

        foreach (directed[k]) begin
            send_item(directed[k].op, directed[k].slot, directed[k].mag,
                      directed[k].edge_bin, directed[k].colh, directed[k].fixed_h);
        end

        write_all(17'd655, 17'd41, 17'd0, 17'd0, 17'd0, 17'd58982, 17'd655, 17'd50);
        random_items(25);

        write_all(17'd65536, 17'd40960, 17'd40960, 17'd40960, 17'd40960, 17'd65536,
                  17'd65536, 17'd1000);
        calm = 1'b1;
        random_items(25);
        calm = 1'b0;

        write_all($urandom_range(655, 65536), $urandom_range(41, 40960),
                  $urandom_range(0, 40960), $urandom_range(0, 40960),
                  $urandom_range(0, 40960), $urandom_range(58982, 65536),
                  $urandom_range(655, 65536), $urandom_range(50, 1000));
        random_items(40);

        // Decay and alpha set above one.
        write_all(17'd6554, 17'd40960, 17'd4096, 17'd8192, 17'd40960, 17'h1FFFF,
                  17'h1FFFF, 17'd1023);
        random_items(30);

        write_all(17'd6554, 17'd4096, 17'd4096, 17'd4096, 17'd4096, 17'd62259,
                  17'd19661, 17'd200);
        random_items(35);

        drain();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
